### rtl/core/pm3_pkg.sv
// Shared types and constants of the per-channel median-of-three core.
// No dependencies; every other file of the core uses this package.
package pm3_pkg;

  // Fixed widths of the transaction fields and of the configuration port.
  localparam int CHANNEL_W  = 4;
  localparam int READING_W  = 10;
  localparam int MASK_W     = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Register map.
  localparam logic [APB_ADDR_W-1:0] ADDR_ENABLE_MASK = 3'd0;

  // Group count codes: which slot the next reading of a channel fills.
  localparam int GROUP_SIZE = 3;
  localparam logic [1:0] SLOT_FIRST  = 2'd0;
  localparam logic [1:0] SLOT_SECOND = 2'd1;
  localparam logic [1:0] SLOT_THIRD  = 2'd2;

  // Control that travels with a reading from the store stage to the median stage.
  typedef struct packed {
    logic                 valid;
    logic [CHANNEL_W-1:0] channel;
  } pm3_tag_t;

endpackage

### rtl/core/pm3_if.sv
// Valid/ready channel interfaces for the reading input and the median output.
// Depends on pm3_pkg for the field widths.
interface pm3_in_if;
  logic                             valid;
  logic                             ready;
  logic [pm3_pkg::CHANNEL_W-1:0]    channel;
  logic [pm3_pkg::READING_W-1:0]    reading;

  modport source (output valid, output channel, output reading, input ready);
  modport sink (input valid, input channel, input reading, output ready);
endinterface

interface pm3_out_if;
  logic                             valid;
  logic                             ready;
  logic [pm3_pkg::CHANNEL_W-1:0]    out_channel;
  logic [pm3_pkg::READING_W-1:0]    median;

  modport source (output valid, output out_channel, output median, input ready);
  modport sink (input valid, input out_channel, input median, output ready);
endinterface

### rtl/core/pm3_cfg.sv
// APB-style register file holding the channel enable mask.
// Depends on pm3_pkg for the register map and port widths.
module pm3_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pm3_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pm3_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pm3_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [pm3_pkg::MASK_W-1:0]     enable_mask
);
  import pm3_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= '0;
    end else if (wr_en && (paddr == ADDR_ENABLE_MASK)) begin
      enable_mask <= pwdata[MASK_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_ENABLE_MASK) begin
      prdata = {{(APB_DATA_W-MASK_W){1'b0}}, enable_mask};
    end
  end

endmodule

### rtl/core/pm3_store.sv
// Input stage: enable check, per-channel group counts and the two held-reading
// memories, registered into the stage that forms the median. Depends on pm3_pkg.
module pm3_store #(
  parameter int CHANNELS    = 16,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pm3_pkg::CHANNEL_W-1:0] in_channel,
  input  logic [pm3_pkg::READING_W-1:0] in_reading,
  input  logic [pm3_pkg::MASK_W-1:0]    enable_mask,
  input  logic                          downstream_free,
  output pm3_pkg::pm3_tag_t             tag,
  output logic [SAMPLE_BITS-1:0]        latest,
  output logic [SAMPLE_BITS-1:0]        held_first_q,
  output logic [SAMPLE_BITS-1:0]        held_second_q
);
  import pm3_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [1:0]             group_count [CHANNELS];
  logic [SAMPLE_BITS-1:0] held_first  [CHANNELS];
  logic [SAMPLE_BITS-1:0] held_second [CHANNELS];

  logic [CH_W-1:0]        ch_idx;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   accept;
  logic                   enabled;
  logic [1:0]             slot;
  logic [1:0]             slot_next;
  logic                   wr_first;
  logic                   wr_second;
  logic                   completes;

  assign in_ready = !tag.valid || downstream_free;
  assign accept   = in_valid && in_ready;
  assign ch_idx   = CH_W'(in_channel);
  assign sample   = SAMPLE_BITS'(in_reading);
  assign enabled  = (int'(in_channel) < CHANNELS) && enable_mask[in_channel];
  assign slot     = group_count[ch_idx];

  always_comb begin
    slot_next = SLOT_SECOND;
    wr_first  = 1'b0;
    wr_second = 1'b0;
    completes = 1'b0;
    case (slot)
      SLOT_FIRST: begin
        wr_first  = 1'b1;
        slot_next = SLOT_SECOND;
      end
      SLOT_SECOND: begin
        wr_second = 1'b1;
        slot_next = SLOT_THIRD;
      end
      SLOT_THIRD: begin
        completes = 1'b1;
        slot_next = SLOT_FIRST;
      end
      default: begin
        wr_first  = 1'b1;
        slot_next = SLOT_SECOND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        group_count[i] <= SLOT_FIRST;
      end
    end else if (accept && enabled) begin
      group_count[ch_idx] <= slot_next;
    end
  end

  // The third reading of a group is never stored; it goes straight to the
  // median stage next to the two readings read here.
  always_ff @(posedge clk) begin
    if (accept) begin
      held_first_q  <= held_first[ch_idx];
      held_second_q <= held_second[ch_idx];
      if (enabled && wr_first) begin
        held_first[ch_idx] <= sample;
      end
      if (enabled && wr_second) begin
        held_second[ch_idx] <= sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else if (accept) begin
      tag.valid <= enabled && completes;
    end else if (downstream_free) begin
      tag.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag.channel <= in_channel;
      latest      <= sample;
    end
  end

endmodule

### rtl/core/pm3_median.sv
// Median-of-three compare network feeding the output register.
// Depends on pm3_pkg for the tag type and the output field widths.
module pm3_median #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pm3_pkg::pm3_tag_t             tag,
  input  logic [SAMPLE_BITS-1:0]        latest,
  input  logic [SAMPLE_BITS-1:0]        held_first_q,
  input  logic [SAMPLE_BITS-1:0]        held_second_q,
  output logic                          downstream_free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pm3_pkg::CHANNEL_W-1:0] out_channel,
  output logic [pm3_pkg::READING_W-1:0] median
);
  import pm3_pkg::*;

  logic [SAMPLE_BITS-1:0] lo_ab;
  logic [SAMPLE_BITS-1:0] hi_ab;
  logic [SAMPLE_BITS-1:0] lo_hic;
  logic [SAMPLE_BITS-1:0] mid;

  // median(a, b, c) = max(min(a, b), min(max(a, b), c)); ties give the shared value.
  always_comb begin
    lo_ab  = (held_first_q <= held_second_q) ? held_first_q : held_second_q;
    hi_ab  = (held_first_q <= held_second_q) ? held_second_q : held_first_q;
    lo_hic = (hi_ab <= latest) ? hi_ab : latest;
    mid    = (lo_ab >= lo_hic) ? lo_ab : lo_hic;
  end

  assign downstream_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (downstream_free) begin
      out_valid <= tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (downstream_free && tag.valid) begin
      out_channel <= tag.channel;
      median      <= READING_W'(mid);
    end
  end

endmodule

### rtl/core/per_channel_median_of_three_core.sv
// Top level of the per-channel median-of-three core.
// Depends on pm3_pkg, pm3_if, pm3_cfg, pm3_store and pm3_median.
//
//   Port      | Direction | Fields                 | Handshake
//   ----------+-----------+------------------------+-----------------------
//   samples   | in        | channel, reading       | valid/ready
//   results   | out       | out_channel, median    | valid/ready
//   APB       | in        | enable_mask            | psel/penable, pready=1
//
// One reading is accepted every cycle while samples.ready is high. A reading
// that completes a group of three gives its transaction on results through
// the median-stage register, loaded with the held readings of its channel,
// then the compare network into the output register. Others give nothing.
// Synchronous reset clears the group counts, the enable mask and all valids.
// samples.ready falls only while both the median stage and the output
// register hold results and results.ready is low.
module per_channel_median_of_three_core #(
  parameter int CHANNELS    = 16,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  pm3_in_if.sink                         samples,
  pm3_out_if.source                      results,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pm3_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pm3_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pm3_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import pm3_pkg::*;

  logic [MASK_W-1:0]      enable_mask;
  logic                   downstream_free;
  pm3_tag_t               tag;
  logic [SAMPLE_BITS-1:0] latest;
  logic [SAMPLE_BITS-1:0] held_first_q;
  logic [SAMPLE_BITS-1:0] held_second_q;

  pm3_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .enable_mask (enable_mask)
  );

  pm3_store #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (samples.valid),
    .in_ready        (samples.ready),
    .in_channel      (samples.channel),
    .in_reading      (samples.reading),
    .enable_mask     (enable_mask),
    .downstream_free (downstream_free),
    .tag             (tag),
    .latest          (latest),
    .held_first_q    (held_first_q),
    .held_second_q   (held_second_q)
  );

  pm3_median #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_median (
    .clk             (clk),
    .rst             (rst),
    .tag             (tag),
    .latest          (latest),
    .held_first_q    (held_first_q),
    .held_second_q   (held_second_q),
    .downstream_free (downstream_free),
    .out_valid       (results.valid),
    .out_ready       (results.ready),
    .out_channel     (results.out_channel),
    .median          (results.median)
  );

endmodule
